>>> hdl/hbc_pkg.sv
// ----------------------------------------------------------------------------
// hbc_pkg
// Shared types, codes and helpers of the histogram bin counter.
// ----------------------------------------------------------------------------
package hbc_pkg;

  // Sizes
  localparam int MAX_BINS  = 64;
  localparam int VAL_W     = 32;
  localparam int CNT_W     = 32;
  localparam int SEL_W     = 6;
  localparam int BC_W      = 7;
  localparam int CMD_W     = 2;
  localparam int ST_W      = 2;
  localparam int REG_IDX_W = 3;
  localparam int CFG_W     = 32;
  localparam int BIN_W     = $clog2(MAX_BINS);
  localparam int N_W       = $clog2(MAX_BINS + 1);
  localparam int STEP_W    = (BIN_W > 1) ? $clog2(BIN_W) : 1;
  localparam int Q_DEPTH   = 2;
  localparam int QPTR_W    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int QCNT_W    = $clog2(Q_DEPTH + 1);

  typedef logic [VAL_W-1:0]         val_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [SEL_W-1:0]         sel_t;
  typedef logic [BC_W-1:0]          bc_t;
  typedef logic [CMD_W-1:0]         cmd_t;
  typedef logic [ST_W-1:0]          status_t;
  typedef logic [REG_IDX_W-1:0]     reg_idx_t;
  typedef logic [CFG_W-1:0]         cfg_data_t;
  typedef logic [BIN_W-1:0]         bin_t;
  typedef logic [N_W-1:0]           nbin_t;
  typedef logic [STEP_W-1:0]        step_t;
  typedef logic [N_W+VAL_W-1:0]     prod_t;
  typedef logic [VAL_W+BIN_W:0]     wide_t;

  // Commands
  localparam cmd_t CMD_CLEAR = 2'd0;
  localparam cmd_t CMD_LOAD  = 2'd1;
  localparam cmd_t CMD_ADD   = 2'd2;
  localparam cmd_t CMD_READ  = 2'd3;

  // Result status
  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_DROP    = 2'd1;
  localparam status_t ST_REFUSED = 2'd2;
  localparam status_t ST_RANGE   = 2'd3;

  // Register indexes
  localparam reg_idx_t REG_LOWEST_EDGE  = 3'd0;
  localparam reg_idx_t REG_BIN_SPAN     = 3'd1;
  localparam reg_idx_t REG_BAR_COUNT    = 3'd2;
  localparam reg_idx_t REG_COUNT_OUTL   = 3'd3;
  localparam reg_idx_t REG_USE_LOADED   = 3'd4;

  localparam cnt_t CNT_MAX = '1;

  // Work kinds decided by the front end
  typedef enum logic [2:0] {
    K_EMIT,   // result known at once, no store access
    K_CLEAR,  // clear all counts
    K_LOAD,   // write one edge
    K_READ,   // read one count
    K_BUMP,   // bump a known bin
    K_GEN,    // generated edges, bin from offset / bin span
    K_SCAN    // loaded edges, scan downward
  } kind_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_CHECK,
    S_DIV,
    S_SCAN_RD,
    S_SCAN,
    S_CNT_RD,
    S_CNT_WR
  } state_e;

  typedef struct packed {
    cmd_t command;
    val_t value;
    sel_t bin_select;
  } item_t;

  typedef struct packed {
    sel_t    bin_found;
    cnt_t    bin_total;
    status_t status;
  } res_t;

  typedef struct packed {
    val_t lowest_edge;
    val_t bin_span;
    bc_t  bar_count;
    logic count_outliers;
    logic use_loaded_edges;
  } cfg_t;

  typedef struct packed {
    kind_e   kind;
    val_t    value;   // edge value, sample, or offset from lowest edge
    sel_t    bin;
    status_t status;
  } op_t;

  // Bar count clamped to 1..MAX_BINS
  function automatic nbin_t bins_in_use(input bc_t bc);
    nbin_t r;
    if (bc == '0) begin
      r = nbin_t'(1);
    end else if (int'(bc) > MAX_BINS) begin
      r = nbin_t'(MAX_BINS);
    end else begin
      r = nbin_t'(bc);
    end
    return r;
  endfunction

endpackage

>>> hdl/hbc_ram.sv
// ----------------------------------------------------------------------------
// hbc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hbc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> hdl/hbc_front.sv
// ----------------------------------------------------------------------------
// hbc_front
// Takes input words and sorts them into work kinds for the back end.
// ----------------------------------------------------------------------------
module hbc_front (
  input  hbc_pkg::cfg_t  cfg_i,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  hbc_pkg::item_t in_data_i,
  input  logic           full_i,
  output logic           push_o,
  output hbc_pkg::op_t   op_o
);

  hbc_pkg::nbin_t n_use;

  assign n_use      = hbc_pkg::bins_in_use(cfg_i.bar_count);
  assign in_stall_o = full_i;
  assign push_o     = in_valid_i & ~full_i;

  // Command decode and early checks
  always_comb begin
    op_o.kind   = hbc_pkg::K_EMIT;
    op_o.value  = in_data_i.value;
    op_o.bin    = in_data_i.bin_select;
    op_o.status = hbc_pkg::ST_OK;
    unique case (in_data_i.command)
      hbc_pkg::CMD_CLEAR: begin
        op_o.kind = hbc_pkg::K_CLEAR;
        op_o.bin  = '0;
      end
      hbc_pkg::CMD_LOAD: begin
        if (int'(in_data_i.bin_select) >= hbc_pkg::MAX_BINS) begin
          op_o.status = hbc_pkg::ST_RANGE;
        end else begin
          op_o.kind = hbc_pkg::K_LOAD;
        end
      end
      hbc_pkg::CMD_READ: begin
        if (int'(in_data_i.bin_select) >= int'(n_use)) begin
          op_o.status = hbc_pkg::ST_RANGE;
        end else begin
          op_o.kind = hbc_pkg::K_READ;
        end
      end
      default: begin
        // add sample
        op_o.bin = '0;
        if (cfg_i.use_loaded_edges) begin
          if (!cfg_i.count_outliers) begin
            op_o.status = hbc_pkg::ST_REFUSED;
          end else begin
            op_o.kind = hbc_pkg::K_SCAN;
          end
        end else if (in_data_i.value < cfg_i.lowest_edge) begin
          if (!cfg_i.count_outliers) begin
            op_o.status = hbc_pkg::ST_DROP;
          end else begin
            op_o.kind = hbc_pkg::K_BUMP;
          end
        end else begin
          op_o.kind  = hbc_pkg::K_GEN;
          op_o.value = in_data_i.value - cfg_i.lowest_edge;
        end
      end
    endcase
  end

endmodule

>>> hdl/hbc_fifo.sv
// ----------------------------------------------------------------------------
// hbc_fifo
// Short queue of classified words between front and back end.
// ----------------------------------------------------------------------------
module hbc_fifo (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  hbc_pkg::op_t wdata_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         valid_o,
  output hbc_pkg::op_t rdata_o
);

  hbc_pkg::op_t                       slot_q [hbc_pkg::Q_DEPTH];
  logic [hbc_pkg::QPTR_W-1:0]         wptr_q, wptr_d, rptr_q, rptr_d;
  logic [hbc_pkg::QCNT_W-1:0]         fill_q, fill_d;
  logic                               do_push, do_pop;

  assign full_o  = (int'(fill_q) == hbc_pkg::Q_DEPTH);
  assign valid_o = (fill_q != '0);
  assign rdata_o = slot_q[rptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  // Pointer and fill update
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    fill_d = fill_q;
    if (do_push) begin
      wptr_d = (int'(wptr_q) == hbc_pkg::Q_DEPTH - 1) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (int'(rptr_q) == hbc_pkg::Q_DEPTH - 1) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_d = fill_q + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      fill_q <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      fill_q <= fill_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= wdata_i;
    end
  end

endmodule

>>> hdl/hbc_back.sv
// ----------------------------------------------------------------------------
// hbc_back
// Carries out queued work: bin search, divide, count store update, result.
// ----------------------------------------------------------------------------
module hbc_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  hbc_pkg::cfg_t cfg_i,
  input  logic          q_valid_i,
  input  hbc_pkg::op_t  q_data_i,
  output logic          q_pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output hbc_pkg::res_t out_data_o
);

  hbc_pkg::state_e state_q, state_d;

  hbc_pkg::val_t   val_q, val_d;
  hbc_pkg::val_t   rem_q, rem_d;
  hbc_pkg::bin_t   quo_q, quo_d;
  hbc_pkg::step_t  step_q, step_d;
  hbc_pkg::prod_t  prod_q, prod_d;
  hbc_pkg::bin_t   cnt_addr_q, cnt_addr_d;
  hbc_pkg::bin_t   edge_addr_q, edge_addr_d;
  hbc_pkg::bin_t   chk_q, chk_d;
  logic            is_read_q, is_read_d;
  hbc_pkg::res_t   out_q, out_d;
  logic            out_vld_q, out_vld_d;
  logic [hbc_pkg::MAX_BINS-1:0] cnt_vld_q, cnt_vld_d;

  hbc_pkg::nbin_t  n_use, n_m1;
  logic            fin, imm, drop, sat, div_ge, scan_hit;
  hbc_pkg::wide_t  div_sub;
  hbc_pkg::bin_t   quo_new, k_div;
  hbc_pkg::cnt_t   cnt_rdata, cnt_cur, cnt_nxt;
  hbc_pkg::val_t   edge_rdata;
  logic            cnt_we, edge_we;

  // Stores
  hbc_ram #(.WIDTH(hbc_pkg::CNT_W), .DEPTH(hbc_pkg::MAX_BINS)) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_addr_q),
    .wdata_i (cnt_nxt),
    .raddr_i (cnt_addr_q),
    .rdata_o (cnt_rdata)
  );

  hbc_ram #(.WIDTH(hbc_pkg::VAL_W), .DEPTH(hbc_pkg::MAX_BINS)) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (edge_we),
    .waddr_i (hbc_pkg::bin_t'(q_data_i.bin)),
    .wdata_i (q_data_i.value),
    .raddr_i (edge_addr_q),
    .rdata_o (edge_rdata)
  );

  // Shared conditions
  assign n_use = hbc_pkg::bins_in_use(cfg_i.bar_count);
  assign n_m1  = n_use - hbc_pkg::nbin_t'(1);
  assign fin   = ~out_vld_q | ~out_stall_i;
  assign imm   = (q_data_i.kind == hbc_pkg::K_EMIT) ||
                 (q_data_i.kind == hbc_pkg::K_CLEAR) ||
                 (q_data_i.kind == hbc_pkg::K_LOAD);

  // Dropped when outliers are off and the offset passes the top edge
  assign drop = ~cfg_i.count_outliers && (hbc_pkg::prod_t'(val_q) > prod_q);
  // Quotient of at least MAX_BINS, or zero width: top bin
  assign sat  = (cfg_i.bin_span == '0) ||
                (hbc_pkg::wide_t'(val_q) >=
                 (hbc_pkg::wide_t'(cfg_i.bin_span) << hbc_pkg::BIN_W));

  // One restoring divide step
  assign div_sub = hbc_pkg::wide_t'(cfg_i.bin_span) << step_q;
  assign div_ge  = hbc_pkg::wide_t'(rem_q) >= div_sub;
  assign quo_new = div_ge ? (quo_q | (hbc_pkg::bin_t'(1) << step_q)) : quo_q;
  assign k_div   = (hbc_pkg::nbin_t'(quo_new) > n_m1) ? hbc_pkg::bin_t'(n_m1) : quo_new;

  assign scan_hit = (edge_rdata <= val_q);

  // Count read-modify-write, invalid entries read as zero
  assign cnt_cur = cnt_vld_q[cnt_addr_q] ? cnt_rdata : '0;
  assign cnt_nxt = (cnt_cur == hbc_pkg::CNT_MAX) ? cnt_cur : cnt_cur + 1'b1;

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      hbc_pkg::S_IDLE: begin
        if (q_valid_i && (!imm || fin)) begin
          unique case (q_data_i.kind) inside
            hbc_pkg::K_READ, hbc_pkg::K_BUMP: state_d = hbc_pkg::S_CNT_RD;
            hbc_pkg::K_GEN:                   state_d = hbc_pkg::S_MUL;
            hbc_pkg::K_SCAN:                  state_d = hbc_pkg::S_SCAN_RD;
            default:                          state_d = hbc_pkg::S_IDLE;
          endcase
        end
      end
      hbc_pkg::S_MUL: state_d = hbc_pkg::S_CHECK;
      hbc_pkg::S_CHECK: begin
        if (drop) begin
          if (fin) state_d = hbc_pkg::S_IDLE;
        end else if (sat) begin
          state_d = hbc_pkg::S_CNT_RD;
        end else begin
          state_d = hbc_pkg::S_DIV;
        end
      end
      hbc_pkg::S_DIV: begin
        if (step_q == '0) state_d = hbc_pkg::S_CNT_RD;
      end
      hbc_pkg::S_SCAN_RD: state_d = hbc_pkg::S_SCAN;
      hbc_pkg::S_SCAN: begin
        if (scan_hit || chk_q == '0) state_d = hbc_pkg::S_CNT_RD;
      end
      hbc_pkg::S_CNT_RD: state_d = hbc_pkg::S_CNT_WR;
      hbc_pkg::S_CNT_WR: begin
        if (fin) state_d = hbc_pkg::S_IDLE;
      end
      default: state_d = hbc_pkg::S_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    q_pop_o     = 1'b0;
    cnt_we      = 1'b0;
    edge_we     = 1'b0;
    out_vld_d   = out_vld_q & out_stall_i;
    out_d       = out_q;
    cnt_vld_d   = cnt_vld_q;
    val_d       = val_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    step_d      = step_q;
    prod_d      = prod_q;
    cnt_addr_d  = cnt_addr_q;
    edge_addr_d = edge_addr_q;
    chk_d       = chk_q;
    is_read_d   = is_read_q;
    unique case (state_q)
      hbc_pkg::S_IDLE: begin
        if (q_valid_i && (!imm || fin)) begin
          q_pop_o     = 1'b1;
          val_d       = q_data_i.value;
          is_read_d   = (q_data_i.kind == hbc_pkg::K_READ);
          cnt_addr_d  = hbc_pkg::bin_t'(q_data_i.bin);
          edge_addr_d = hbc_pkg::bin_t'(n_m1);
          case (q_data_i.kind)
            hbc_pkg::K_EMIT: begin
              out_vld_d = 1'b1;
              out_d     = '{q_data_i.bin, '0, q_data_i.status};
            end
            hbc_pkg::K_CLEAR: begin
              cnt_vld_d = '0;
              out_vld_d = 1'b1;
              out_d     = '{'0, '0, hbc_pkg::ST_OK};
            end
            hbc_pkg::K_LOAD: begin
              edge_we   = 1'b1;
              out_vld_d = 1'b1;
              out_d     = '{q_data_i.bin, '0, hbc_pkg::ST_OK};
            end
            default: ;
          endcase
        end
      end
      hbc_pkg::S_MUL: begin
        prod_d = hbc_pkg::prod_t'(n_use) * hbc_pkg::prod_t'(cfg_i.bin_span);
      end
      hbc_pkg::S_CHECK: begin
        if (drop) begin
          if (fin) begin
            out_vld_d = 1'b1;
            out_d     = '{'0, '0, hbc_pkg::ST_DROP};
          end
        end else if (sat) begin
          cnt_addr_d = hbc_pkg::bin_t'(n_m1);
        end else begin
          rem_d  = val_q;
          quo_d  = '0;
          step_d = hbc_pkg::step_t'(hbc_pkg::BIN_W - 1);
        end
      end
      hbc_pkg::S_DIV: begin
        if (div_ge) rem_d = rem_q - hbc_pkg::val_t'(div_sub);
        quo_d = quo_new;
        if (step_q == '0) begin
          cnt_addr_d = k_div;
        end else begin
          step_d = step_q - 1'b1;
        end
      end
      hbc_pkg::S_SCAN_RD: begin
        chk_d = edge_addr_q;
        if (edge_addr_q != '0) edge_addr_d = edge_addr_q - 1'b1;
      end
      hbc_pkg::S_SCAN: begin
        // edge data of chk_q is on the read port
        if (scan_hit || chk_q == '0) begin
          cnt_addr_d = scan_hit ? chk_q : '0;
        end else begin
          chk_d = edge_addr_q;
          if (edge_addr_q != '0) edge_addr_d = edge_addr_q - 1'b1;
        end
      end
      hbc_pkg::S_CNT_RD: ;
      hbc_pkg::S_CNT_WR: begin
        if (fin) begin
          out_vld_d = 1'b1;
          if (is_read_q) begin
            out_d = '{hbc_pkg::sel_t'(cnt_addr_q), cnt_cur, hbc_pkg::ST_OK};
          end else begin
            cnt_we                = 1'b1;
            cnt_vld_d[cnt_addr_q] = 1'b1;
            out_d = '{hbc_pkg::sel_t'(cnt_addr_q), cnt_nxt, hbc_pkg::ST_OK};
          end
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= hbc_pkg::S_IDLE;
      out_vld_q <= 1'b0;
      cnt_vld_q <= '0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
      cnt_vld_q <= cnt_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    val_q       <= val_d;
    rem_q       <= rem_d;
    quo_q       <= quo_d;
    step_q      <= step_d;
    prod_q      <= prod_d;
    cnt_addr_q  <= cnt_addr_d;
    edge_addr_q <= edge_addr_d;
    chk_q       <= chk_d;
    is_read_q   <= is_read_d;
    out_q       <= out_d;
  end

endmodule

>>> hdl/histogram_bin_counter_top.sv
// ----------------------------------------------------------------------------
// histogram_bin_counter_top
// Histogram engine on unsigned Q16.16 samples with generated or loaded edges.
// ----------------------------------------------------------------------------
// Every input word gives exactly one result word. Words pass a two-entry queue
// into a sequencer that handles one word at a time: clear, edge load, refused
// mode and samples below the lowest edge that are dropped are answered from
// the idle state; a sample dropped above the top edge passes the range
// multiply and check; a count read or a sample below the lowest edge goes
// through the count store read, then write-back; a sample on generated edges
// passes the range multiply and the restoring divide that yields one
// bin-index bit per cycle (6 steps for 64 bins); a sample on loaded edges
// passes the downward scan that reads one edge store entry per cycle over the
// bins in use. Clearing the counts resets per-bin valid flags; there is no
// clearing pass after reset. The user must write configuration only while no
// word is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module histogram_bin_counter_top (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  hbc_pkg::item_t         in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output hbc_pkg::res_t          out_data_o,
  input  logic                   cfg_we_i,
  input  hbc_pkg::reg_idx_t      cfg_idx_i,
  input  hbc_pkg::cfg_data_t     cfg_wdata_i
);

  hbc_pkg::cfg_t cfg_q, cfg_d;
  hbc_pkg::op_t  fr_op, q_op;
  logic          fr_push, q_full, q_valid, q_pop;

  // Configuration registers
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        hbc_pkg::REG_LOWEST_EDGE: cfg_d.lowest_edge      = hbc_pkg::val_t'(cfg_wdata_i);
        hbc_pkg::REG_BIN_SPAN:    cfg_d.bin_span         = hbc_pkg::val_t'(cfg_wdata_i);
        hbc_pkg::REG_BAR_COUNT:   cfg_d.bar_count        = cfg_wdata_i[hbc_pkg::BC_W-1:0];
        hbc_pkg::REG_COUNT_OUTL:  cfg_d.count_outliers   = cfg_wdata_i[0];
        hbc_pkg::REG_USE_LOADED:  cfg_d.use_loaded_edges = cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lowest_edge      <= '0;
      cfg_q.bin_span         <= hbc_pkg::val_t'(65536);
      cfg_q.bar_count        <= hbc_pkg::bc_t'(35);
      cfg_q.count_outliers   <= 1'b1;
      cfg_q.use_loaded_edges <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  hbc_front u_front (
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .full_i     (q_full),
    .push_o     (fr_push),
    .op_o       (fr_op)
  );

  hbc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fr_push),
    .wdata_i (fr_op),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rdata_o (q_op)
  );

  hbc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_data_i    (q_op),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> hdl/hbc_checker.sv
// ----------------------------------------------------------------------------
// hbc_checker
// Port-level checks of the histogram bin counter, bound to the top level.
// ----------------------------------------------------------------------------
module hbc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input hbc_pkg::item_t     in_data_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input hbc_pkg::res_t      out_data_o,
  input logic               cfg_we_i,
  input hbc_pkg::reg_idx_t  cfg_idx_i,
  input hbc_pkg::cfg_data_t cfg_wdata_i
);

  // A stalled input word holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_data_i))
    else $error("input word changed while stalled");

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word changed while stalled");

  // Register writes land only while no result waits, with known data
  a_cfg_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |-> !out_valid_o && !$isunknown({cfg_idx_i, cfg_wdata_i}))
    else $error("register write while a result is pending");

  // Dropped and refused samples carry no bin and no count
  a_drop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == hbc_pkg::ST_DROP ||
                    out_data_o.status == hbc_pkg::ST_REFUSED)
    |-> out_data_o.bin_found == '0 && out_data_o.bin_total == '0)
    else $error("dropped or refused sample shows a bin or count");

  // Out-of-range index gives a zero count
  a_range_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == hbc_pkg::ST_RANGE
    |-> out_data_o.bin_total == '0)
    else $error("out-of-range index shows a count");

endmodule

bind histogram_bin_counter_top hbc_checker u_hbc_checker (.*);

>>> tb/hist_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hist_checker
// Watches the word and register channels of the histogram bin counter, keeps
// its own copy of the registers, counts and edges, works out the result of
// every accepted input word and compares it with what the block returns.
// ----------------------------------------------------------------------------
module hist_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  hbc_pkg::item_t     in_data_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  hbc_pkg::res_t      out_data_i,
  input  logic               cfg_we_i,
  input  hbc_pkg::reg_idx_t  cfg_idx_i,
  input  hbc_pkg::cfg_data_t cfg_wdata_i,
  output int                 words_left_o,
  output int                 mismatch_count_o,
  output int                 results_seen_o
);

  // Shadow of the register file
  hbc_pkg::val_t lowest_sh;
  hbc_pkg::val_t width_sh;
  hbc_pkg::bc_t  bars_sh;
  logic          keep_outliers_sh;
  logic          loaded_sh;

  // Shadow of the count and edge stores
  hbc_pkg::cnt_t bin_count [hbc_pkg::MAX_BINS];
  hbc_pkg::val_t edge_copy [hbc_pkg::MAX_BINS];

  // Results still owed by the block, oldest first
  hbc_pkg::res_t awaited_results [$];
  hbc_pkg::res_t want;

  // Effect of one input word on the shadow state, and the word it returns
  function automatic hbc_pkg::res_t bin_outcome(input hbc_pkg::item_t w);
    hbc_pkg::res_t r;
    int            n;
    int            k;
    logic [63:0]   d64;
    logic [63:0]   span64;
    logic [63:0]   q64;
    r = '0;
    k = -1;
    // bar count of 0 acts as 1, above the store size as the store size
    if (bars_sh == '0) n = 1;
    else if (int'(bars_sh) > hbc_pkg::MAX_BINS) n = hbc_pkg::MAX_BINS;
    else n = int'(bars_sh);
    case (w.command)
      hbc_pkg::CMD_CLEAR: begin
        for (int i = 0; i < hbc_pkg::MAX_BINS; i++) bin_count[i] = '0;
      end
      hbc_pkg::CMD_LOAD: begin
        edge_copy[w.bin_select] = w.value;
        r.bin_found = w.bin_select;
      end
      hbc_pkg::CMD_READ: begin
        r.bin_found = w.bin_select;
        if (int'(w.bin_select) >= n) r.status = hbc_pkg::ST_RANGE;
        else r.bin_total = bin_count[w.bin_select];
      end
      default: begin
        if (loaded_sh) begin
          // loaded edges cannot drop outliers
          if (!keep_outliers_sh) begin
            r.status = hbc_pkg::ST_REFUSED;
          end else begin
            // largest bin whose edge is at or below the sample, else bin 0
            k = 0;
            for (int j = 0; j < n; j++) begin
              if (edge_copy[j] <= w.value) k = j;
            end
          end
        end else if (w.value < lowest_sh) begin
          if (!keep_outliers_sh) r.status = hbc_pkg::ST_DROP;
          else k = 0;
        end else begin
          d64    = 64'(w.value) - 64'(lowest_sh);
          span64 = 64'(n) * 64'(width_sh);
          if (!keep_outliers_sh && d64 > span64) begin
            r.status = hbc_pkg::ST_DROP;
          end else if (width_sh == '0) begin
            k = n - 1;
          end else begin
            q64 = d64 / 64'(width_sh);
            k = (q64 > 64'(n - 1)) ? n - 1 : int'(q64);
          end
        end
        if (k >= 0) begin
          if (bin_count[k] != hbc_pkg::CNT_MAX) bin_count[k] = bin_count[k] + 1'b1;
          r.bin_found = hbc_pkg::sel_t'(k);
          r.bin_total = bin_count[k];
        end
      end
    endcase
    return r;
  endfunction

  // Count a failure; only the first few are printed
  task automatic note_mismatch(input string what, input hbc_pkg::res_t exp_w,
                               input hbc_pkg::res_t got_w);
    mismatch_count_o = mismatch_count_o + 1;
    if (mismatch_count_o <= 10) begin
      $display("[%0t] %s: expected bin=%0d total=%h status=%0d, got bin=%0d total=%h status=%0d",
               $realtime, what, exp_w.bin_found, exp_w.bin_total, exp_w.status,
               got_w.bin_found, got_w.bin_total, got_w.status);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lowest_sh        = '0;
      width_sh         = 32'h0001_0000;
      bars_sh          = 7'd35;
      keep_outliers_sh = 1'b1;
      loaded_sh        = 1'b0;
      for (int i = 0; i < hbc_pkg::MAX_BINS; i++) begin
        bin_count[i] = '0;
        edge_copy[i] = '0;
      end
      awaited_results.delete();
      words_left_o     = 0;
      mismatch_count_o = 0;
      results_seen_o   = 0;
    end else begin
      // register writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          hbc_pkg::REG_LOWEST_EDGE: lowest_sh        = cfg_wdata_i[hbc_pkg::VAL_W-1:0];
          hbc_pkg::REG_BIN_SPAN:    width_sh         = cfg_wdata_i[hbc_pkg::VAL_W-1:0];
          hbc_pkg::REG_BAR_COUNT:   bars_sh          = cfg_wdata_i[hbc_pkg::BC_W-1:0];
          hbc_pkg::REG_COUNT_OUTL:  keep_outliers_sh = cfg_wdata_i[0];
          hbc_pkg::REG_USE_LOADED:  loaded_sh        = cfg_wdata_i[0];
          default: ;
        endcase
      end
      // result words against the oldest expectation
      if (out_valid_i && !out_stall_i) begin
        results_seen_o = results_seen_o + 1;
        if (awaited_results.size() == 0) begin
          note_mismatch("result with nothing awaited", '0, out_data_i);
        end else begin
          want = awaited_results.pop_front();
          if (out_data_i.bin_found !== want.bin_found ||
              out_data_i.bin_total !== want.bin_total ||
              out_data_i.status    !== want.status) begin
            note_mismatch("result mismatch", want, out_data_i);
          end
        end
      end
      // input words
      if (in_valid_i && !in_stall_i) begin
        awaited_results.push_back(bin_outcome(in_data_i));
      end
      words_left_o = awaited_results.size();
    end
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Regression bench of the histogram bin counter. A directed opening walks the
// corner cases of binning, dropping, refusal and range checks, then random
// phases change the settings and send bursty word streams against a stalling
// receiver, while hist_checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;

  localparam int  WORD_TARGET = 1000;
  localparam int  END_WAIT    = 100;
  localparam int  CYCLE_LIMIT = 1000000;

  logic               clk         = 1'b0;
  logic               rst_n       = 1'b0;
  logic               in_valid    = 1'b0;
  logic               in_stall;
  hbc_pkg::item_t     in_data     = '0;
  logic               out_valid;
  logic               out_stall   = 1'b0;
  hbc_pkg::res_t      out_data;
  logic               cfg_we      = 1'b0;
  hbc_pkg::reg_idx_t  cfg_idx     = hbc_pkg::REG_LOWEST_EDGE;
  hbc_pkg::cfg_data_t cfg_wdata   = '0;

  int words_left;
  int mismatch_count;
  int results_seen;

  // Settings in force, used only to shape the stimulus
  hbc_pkg::val_t cur_lo     = '0;
  hbc_pkg::val_t cur_w      = 32'h0001_0000;
  int            cur_n      = 35;
  logic          cur_loaded = 1'b0;
  hbc_pkg::val_t edge_plan [hbc_pkg::MAX_BINS];

  int burst_left = 1;
  int words_sent = 0;
  int n_clear    = 0;
  int n_load     = 0;
  int n_add      = 0;
  int n_read     = 0;
  int phases     = 0;
  int cycles     = 0;

  // Receiver stall pattern state
  int stall_mode = 0;
  int stall_span = 0;

  histogram_bin_counter_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  hist_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .in_data_i        (in_data),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .out_data_i       (out_data),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata),
    .words_left_o     (words_left),
    .mismatch_count_o (mismatch_count),
    .results_seen_o   (results_seen)
  );

  always #10 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results still awaited", cycles, words_left);
      $display("Regression FAIL");
      $finish;
    end
  end

  // Receiver: stretches of free flow, light, heavy and square-wave stalling
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_span == 0) begin
        stall_mode <= $urandom_range(0, 3);
        stall_span <= $urandom_range(8, 120);
      end else begin
        stall_span <= stall_span - 1;
      end
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        2:       out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= stall_span[3];
      endcase
    end
  end

  function automatic hbc_pkg::item_t mk_word(input hbc_pkg::cmd_t c, input hbc_pkg::val_t v,
                                             input hbc_pkg::sel_t s);
    hbc_pkg::item_t w;
    w.command    = c;
    w.value      = v;
    w.bin_select = s;
    return w;
  endfunction

  // Sample for generated edges: near edges, inside the range, below it, or anywhere
  function automatic hbc_pkg::val_t gen_sample();
    logic [63:0]   span;
    logic [63:0]   pos;
    logic [31:0]   hi_r;
    logic [31:0]   lo_r;
    hbc_pkg::val_t s;
    int unsigned   pick;
    pick = $urandom_range(0, 9);
    span = 64'(cur_n) * 64'(cur_w);
    hi_r = $urandom;
    lo_r = $urandom;
    if (pick < 2) begin
      s = $urandom;
    end else if (pick < 5) begin
      pos = 64'(cur_lo) + 64'($urandom_range(0, cur_n)) * 64'(cur_w);
      s = hbc_pkg::val_t'(pos + 64'($urandom_range(0, 2)) - 64'd1);
    end else if (pick < 9) begin
      s = hbc_pkg::val_t'(64'(cur_lo) + ({hi_r, lo_r} % (span + 64'd1)));
    end else begin
      s = cur_lo - hbc_pkg::val_t'($urandom_range(1, 16));
    end
    return s;
  endfunction

  // Sample for loaded edges: on, just off, or far from a stored edge
  function automatic hbc_pkg::val_t loaded_sample();
    int            j;
    hbc_pkg::val_t s;
    j = $urandom_range(0, cur_n - 1);
    case ($urandom_range(0, 5))
      0:       s = $urandom;
      1:       s = edge_plan[j] - 32'd1;
      2:       s = edge_plan[j] + 32'd1;
      3:       s = ($urandom_range(0, 1) != 0) ? '0 : '1;
      default: s = edge_plan[j];
    endcase
    return s;
  endfunction

  function automatic hbc_pkg::item_t random_word();
    int unsigned    roll;
    hbc_pkg::item_t w;
    hbc_pkg::sel_t  s;
    hbc_pkg::val_t  v;
    roll = $urandom_range(0, 99);
    s = hbc_pkg::sel_t'($urandom);
    if (roll < 3) begin
      w = mk_word(hbc_pkg::CMD_CLEAR, $urandom, s);
    end else if (roll < 15) begin
      if (roll < 13) s = hbc_pkg::sel_t'($urandom_range(0, cur_n - 1));
      w = mk_word(hbc_pkg::CMD_READ, $urandom, s);
    end else if (roll < 23) begin
      // keep loaded edges roughly in order, with some unordered loads
      v = ($urandom_range(0, 2) == 0) ?
          hbc_pkg::val_t'($urandom) :
          edge_plan[s] + hbc_pkg::val_t'($urandom_range(0, 32'h0000_8000));
      w = mk_word(hbc_pkg::CMD_LOAD, v, s);
    end else begin
      w = mk_word(hbc_pkg::CMD_ADD, cur_loaded ? loaded_sample() : gen_sample(), s);
    end
    return w;
  endfunction

  // Send one word and hold it until accepted; gaps come between bursts
  task automatic issue(input hbc_pkg::item_t w);
    int gap;
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    words_sent++;
    case (w.command)
      hbc_pkg::CMD_CLEAR: n_clear++;
      hbc_pkg::CMD_LOAD: begin
        n_load++;
        edge_plan[w.bin_select] = w.value;
      end
      hbc_pkg::CMD_ADD:   n_add++;
      default:            n_read++;
    endcase
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if ($urandom_range(0, 9) == 0) gap = $urandom_range(20, 40);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (words_left != 0) @(negedge clk);
  endtask

  task automatic put_reg(input hbc_pkg::reg_idx_t idx, input hbc_pkg::cfg_data_t data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(negedge clk);
  endtask

  // Write every register once the block has gone quiet
  task automatic apply_settings(input hbc_pkg::val_t lo, input hbc_pkg::val_t w,
                                input hbc_pkg::bc_t bc, input logic outl,
                                input logic loaded);
    wait_idle();
    put_reg(hbc_pkg::REG_LOWEST_EDGE, hbc_pkg::cfg_data_t'(lo));
    put_reg(hbc_pkg::REG_BIN_SPAN,    hbc_pkg::cfg_data_t'(w));
    put_reg(hbc_pkg::REG_BAR_COUNT,   hbc_pkg::cfg_data_t'(bc));
    put_reg(hbc_pkg::REG_COUNT_OUTL,  hbc_pkg::cfg_data_t'(outl));
    put_reg(hbc_pkg::REG_USE_LOADED,  hbc_pkg::cfg_data_t'(loaded));
    cfg_we <= 1'b0;
    cur_lo     = lo;
    cur_w      = w;
    cur_n      = (bc == '0) ? 1 :
                 (int'(bc) > hbc_pkg::MAX_BINS) ? hbc_pkg::MAX_BINS : int'(bc);
    cur_loaded = loaded;
    phases++;
  endtask

  // Fill every edge in use: ascending with repeats, all equal, or unordered
  task automatic preload_edges();
    hbc_pkg::val_t e;
    hbc_pkg::val_t step;
    int            style;
    style = $urandom_range(0, 9);
    e     = $urandom_range(0, 32'h0002_0000);
    step  = $urandom_range(0, 32'h0003_0000);
    for (int j = 0; j < cur_n; j++) begin
      if (style == 0) begin
        issue(mk_word(hbc_pkg::CMD_LOAD, e, hbc_pkg::sel_t'(j)));
      end else if (style < 3) begin
        issue(mk_word(hbc_pkg::CMD_LOAD, $urandom, hbc_pkg::sel_t'(j)));
      end else begin
        issue(mk_word(hbc_pkg::CMD_LOAD, e, hbc_pkg::sel_t'(j)));
        e = e + hbc_pkg::val_t'($urandom_range(0, step));
      end
    end
  endtask

  initial begin
    hbc_pkg::val_t lo;
    hbc_pkg::val_t w;
    hbc_pkg::bc_t  bc;
    logic          outl;
    logic          loaded;
    int            len;
    for (int i = 0; i < hbc_pkg::MAX_BINS; i++) edge_plan[i] = '0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // Directed: reset settings, 35 unit bins from zero
    issue(mk_word(hbc_pkg::CMD_READ, '0, 6'd0));
    issue(mk_word(hbc_pkg::CMD_ADD, '0, '1));
    issue(mk_word(hbc_pkg::CMD_ADD, '1, '0));
    issue(mk_word(hbc_pkg::CMD_ADD, 32'h0001_0000, 6'd0));
    issue(mk_word(hbc_pkg::CMD_ADD, 32'h0000_FFFF, 6'd0));
    issue(mk_word(hbc_pkg::CMD_READ, '1, 6'd34));
    issue(mk_word(hbc_pkg::CMD_READ, '0, 6'd35));
    issue(mk_word(hbc_pkg::CMD_READ, '0, 6'd63));
    issue(mk_word(hbc_pkg::CMD_LOAD, '1, 6'd63));
    issue(mk_word(hbc_pkg::CMD_LOAD, '0, 6'd0));
    issue(mk_word(hbc_pkg::CMD_CLEAR, '1, '1));
    issue(mk_word(hbc_pkg::CMD_READ, '0, 6'd34));

    // Outliers dropped: below the range, on its top edge, just above it
    apply_settings(32'h0005_0000, 32'h0001_0000, 7'd4, 1'b0, 1'b0);
    issue(mk_word(hbc_pkg::CMD_ADD, 32'h0004_FFFF, 6'd0));
    issue(mk_word(hbc_pkg::CMD_ADD, 32'h0009_0000, 6'd0));
    issue(mk_word(hbc_pkg::CMD_ADD, 32'h0009_0001, 6'd0));
    issue(mk_word(hbc_pkg::CMD_ADD, 32'h0005_0000, 6'd0));

    // Zero bin span: at the lowest edge goes to the top bin, above it drops
    apply_settings(32'h0005_0000, '0, 7'd4, 1'b0, 1'b0);
    issue(mk_word(hbc_pkg::CMD_ADD, 32'h0005_0000, 6'd0));
    issue(mk_word(hbc_pkg::CMD_ADD, 32'h0005_0001, 6'd0));

    // Bar count of zero acts as one bin
    apply_settings('1, '0, 7'd0, 1'b1, 1'b0);
    issue(mk_word(hbc_pkg::CMD_ADD, '1, 6'd0));
    issue(mk_word(hbc_pkg::CMD_ADD, '0, 6'd0));
    issue(mk_word(hbc_pkg::CMD_READ, '0, 6'd1));

    // Bar count above the store size acts as the store size
    apply_settings('0, 32'd1, 7'd127, 1'b1, 1'b0);
    issue(mk_word(hbc_pkg::CMD_ADD, '1, 6'd0));
    issue(mk_word(hbc_pkg::CMD_ADD, 32'd5, 6'd0));

    // Loaded edges with outliers dropped is refused
    apply_settings('0, '1, 7'd64, 1'b0, 1'b1);
    issue(mk_word(hbc_pkg::CMD_ADD, '0, 6'd0));

    // Random phases, each under fresh settings
    while (words_sent < WORD_TARGET) begin
      case ($urandom_range(0, 3))
        0:       lo = '0;
        1:       lo = '1;
        2:       lo = $urandom;
        default: lo = $urandom_range(0, 32'h0010_0000);
      endcase
      case ($urandom_range(0, 5))
        0:       w = '0;
        1:       w = 32'd1;
        2:       w = '1;
        3:       w = 32'h0001_0000;
        4:       w = $urandom_range(16, 32'h0004_0000);
        default: w = $urandom;
      endcase
      case ($urandom_range(0, 6))
        0:       bc = 7'd0;
        1:       bc = 7'd1;
        2:       bc = 7'd64;
        3:       bc = 7'd127;
        4:       bc = hbc_pkg::bc_t'($urandom_range(65, 127));
        default: bc = hbc_pkg::bc_t'($urandom_range(2, 64));
      endcase
      loaded = ($urandom_range(0, 4) < 2);
      outl   = loaded ? ($urandom_range(0, 3) != 0) : 1'($urandom_range(0, 1));
      apply_settings(lo, w, bc, outl, loaded);
      if (loaded) preload_edges();
      len = $urandom_range(60, 110);
      repeat (len) issue(random_word());
    end

    wait_idle();
    repeat (END_WAIT) @(negedge clk);

    $display("Summary: %0d words over %0d settings phases:", words_sent, phases);
    $display("Summary: %0d adds, %0d reads, %0d loads, %0d clears; %0d results checked",
             n_add, n_read, n_load, n_clear, results_seen);
    if (mismatch_count == 0 && words_left == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/hbc_pkg.sv
hdl/hbc_ram.sv
hdl/hbc_front.sv
hdl/hbc_fifo.sv
hdl/hbc_back.sv
hdl/histogram_bin_counter_top.sv
hdl/hbc_checker.sv
tb/hist_checker.sv
tb/tb.sv
